// ===== hw/rtl/tpi_pkg.sv =====
// tpi_pkg: shared constants, types and the CORDIC arctangent table for the
// turtle path interpreter. No dependencies; the CORDIC, scale, unit and testbench files refer here.
package tpi_pkg;

    // Parameter defaults
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COUNT_BITS_DEF   = 16;

    // Drawing symbols
    localparam logic [7:0] SYM_FWD   = 8'h46;
    localparam logic [7:0] SYM_LEFT  = 8'h2B;
    localparam logic [7:0] SYM_RIGHT = 8'h2D;

    // Configuration map, register index = paddr[4:2]
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_STEP_LENGTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TURN_ANGLE    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_START_HEADING = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_START_X       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_START_Y       = 3'd4;

    localparam logic [31:0]        RST_STEP_LENGTH   = 32'd65536;
    localparam logic [15:0]        RST_TURN_ANGLE    = 16'd10923;
    localparam logic [15:0]        RST_START_HEADING = 16'd0;
    localparam logic signed [31:0] RST_START_X       = 32'sd13107200;
    localparam logic signed [31:0] RST_START_Y       = 32'sd13107200;

    // CORDIC datapath: Q30 vectors with headroom
    localparam int XY_W = 34;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    typedef struct packed {
        logic signed [XY_W-1:0] cos_v;
        logic signed [XY_W-1:0] sin_v;
    } cs_t;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/tpi_if.sv =====
// tpi_if: valid/ready stream interfaces for symbols in and vertices out.
// No dependencies.
interface tpi_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface tpi_pt_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

// ===== hw/rtl/tpi_cordic.sv =====
// tpi_cordic: iterative CORDIC rotation, one micro-rotation per cycle on a
// shared add/shift datapath. Depends on tpi_pkg.
module tpi_cordic #(
    parameter int ANGLE_BITS   = tpi_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = tpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic                  done,
    output tpi_pkg::cs_t          cs
);

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [IW-1:0]                   step_reg, step_next;
    logic signed [tpi_pkg::XY_W-1:0] x_reg, x_next;
    logic signed [tpi_pkg::XY_W-1:0] y_reg, y_next;
    logic signed [31:0]              z_reg, z_next;
    logic [1:0]                      quad_reg, quad_next;

    logic [31:0]                     phase_a;
    logic signed [tpi_pkg::XY_W-1:0] sh_x, sh_y;
    logic signed [31:0]              at;

    // fold into [-45, 45) degrees plus a quadrant
    assign phase_a = {angle, {(32-ANGLE_BITS){1'b0}}} + 32'h2000_0000;
    assign sh_x    = x_reg >>> step_reg;
    assign sh_y    = y_reg >>> step_reg;
    assign at      = $signed(tpi_pkg::atan_entry(5'(step_reg)));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        quad_next = quad_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            x_next    = tpi_pkg::CORDIC_GAIN;
            y_next    = '0;
            z_next    = $signed({2'b00, phase_a[29:0]}) - 32'sh2000_0000;
            quad_next = phase_a[31:30];
        end
        else if (busy_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - sh_y;
                y_next = y_reg + sh_x;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + sh_y;
                y_next = y_reg - sh_x;
                z_next = z_reg + at;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
    end

    // quadrant unfold
    always_comb
    begin
        case (quad_reg)
            QUAD_0:
            begin
                cs.cos_v = x_reg;
                cs.sin_v = y_reg;
            end
            QUAD_1:
            begin
                cs.cos_v = -y_reg;
                cs.sin_v = x_reg;
            end
            QUAD_2:
            begin
                cs.cos_v = -x_reg;
                cs.sin_v = -y_reg;
            end
            QUAD_3:
            begin
                cs.cos_v = y_reg;
                cs.sin_v = -x_reg;
            end
            default:
            begin
                cs.cos_v = x_reg;
                cs.sin_v = y_reg;
            end
        endcase
    end

    assign done = done_reg;

endmodule

// ===== hw/rtl/tpi_scale.sv =====
// tpi_scale: position update pos + round(d * coef / 2^30), saturated.
// One 32x32 multiplier walks the distance in 32-bit chunks. Depends on tpi_pkg.
module tpi_scale #(
    parameter int D_W = tpi_pkg::COUNT_BITS_DEF + 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [D_W-1:0]                  d,
    input  logic signed [tpi_pkg::XY_W-1:0] coef,
    input  logic signed [31:0]              base,
    output logic                            done,
    output logic signed [31:0]              result
);

    localparam int NCH = (D_W + 31) / 32;
    localparam int PW  = NCH * 32;
    localparam int AW  = PW + 32;
    localparam int MW  = AW + 1 - 30;
    localparam int SW  = MW + 2;
    localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam logic [CW-1:0] LAST_CHUNK = CW'(NCH - 1);

    localparam logic [1:0] SC_IDLE = 2'd0;
    localparam logic [1:0] SC_MUL  = 2'd1;
    localparam logic [1:0] SC_RND  = 2'd2;
    localparam logic [1:0] SC_ADD  = 2'd3;

    logic [1:0]         st_reg, st_next;
    logic [CW-1:0]      chunk_reg, chunk_next;
    logic               done_reg, done_next;
    logic [PW-1:0]      dsh_reg, dsh_next;
    logic [31:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [AW-1:0]      acc_reg, acc_next;
    logic [MW-1:0]      rnd_reg, rnd_next;
    logic signed [31:0] base_reg, base_next;
    logic signed [31:0] res_reg, res_next;

    logic signed [tpi_pkg::XY_W-1:0] neg_coef;
    logic [63:0]                     pp;
    logic [AW:0]                     rsum;
    logic signed [SW-1:0]            mterm, sum;
    logic                            ovf;

    assign neg_coef = -coef;
    assign pp       = dsh_reg[PW-1 -: 32] * mag_reg;
    assign rsum     = {1'b0, acc_reg} + (AW+1)'(32'h2000_0000);
    assign mterm    = neg_reg ? -$signed({2'b00, rnd_reg}) : $signed({2'b00, rnd_reg});
    assign sum      = SW'(base_reg) + mterm;
    assign ovf      = !((&sum[SW-1:31]) || !(|sum[SW-1:31]));

    always_comb
    begin
        st_next    = st_reg;
        chunk_next = chunk_reg;
        done_next  = 1'b0;
        dsh_next   = dsh_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        rnd_next   = rnd_reg;
        base_next  = base_reg;
        res_next   = res_reg;
        case (st_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    neg_next   = coef[tpi_pkg::XY_W-1];
                    mag_next   = coef[tpi_pkg::XY_W-1] ? neg_coef[31:0] : coef[31:0];
                    dsh_next   = PW'(d);
                    acc_next   = '0;
                    chunk_next = '0;
                    base_next  = base;
                    st_next    = SC_MUL;
                end
            end
            SC_MUL:
            begin
                // high chunk first, so the accumulator only ever shifts by a word
                acc_next   = {acc_reg[AW-33:0], 32'h0} + AW'(pp);
                dsh_next   = dsh_reg << 32;
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == LAST_CHUNK)
                begin
                    st_next = SC_RND;
                end
            end
            SC_RND:
            begin
                rnd_next = rsum[AW:30];
                st_next  = SC_ADD;
            end
            SC_ADD:
            begin
                if (ovf)
                begin
                    res_next = sum[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end
                else
                begin
                    res_next = sum[31:0];
                end
                done_next = 1'b1;
                st_next   = SC_IDLE;
            end
            default:
            begin
                st_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= SC_IDLE;
            chunk_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            chunk_reg <= chunk_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsh_reg  <= dsh_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        rnd_reg  <= rnd_next;
        base_reg <= base_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== hw/rtl/turtle_path_interpreter_unit.sv =====
// turtle_path_interpreter_unit: one symbol per beat in, path vertices out.
// Sequence: a symbol that gives no vertex goes through S_SYM, S_TURN for a turn, S_FLUSH
// and S_END at a string end before ready returns; each vertex runs S_SETUP through S_EMIT,
// paced by the iterative CORDIC and the chunked 32x32 multiplier, one pass per distance word.
// Throughput: one symbol at a time; a last turn symbol after an F run gives two vertices.
// Reset: async active low; registers take their reset values, the next beat starts a
// new path from the start registers. No clearing pass.
module turtle_path_interpreter_unit #(
    parameter int ANGLE_BITS   = tpi_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = tpi_pkg::CORDIC_STEPS_DEF,
    parameter int COUNT_BITS   = tpi_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // APB-style configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tpi_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // streams
    tpi_sym_if.sink                    symbols,
    tpi_pt_if.source                   points
);

    localparam int D_W = COUNT_BITS + 32;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // path phase
    localparam logic [1:0] PH_START = 2'd0;   // next symbol opens a new string
    localparam logic [1:0] PH_INIT  = 2'd1;   // leading F run
    localparam logic [1:0] PH_TURNS = 2'd2;   // collecting turns
    localparam logic [1:0] PH_FWD   = 2'd3;   // F run after turns

    // sequencer
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SYM    = 4'd1;
    localparam logic [3:0] S_TURN   = 4'd2;
    localparam logic [3:0] S_FLUSH  = 4'd3;
    localparam logic [3:0] S_END    = 4'd4;
    localparam logic [3:0] S_SETUP  = 4'd5;
    localparam logic [3:0] S_CSTART = 4'd6;
    localparam logic [3:0] S_CWAIT  = 4'd7;
    localparam logic [3:0] S_XSTART = 4'd8;
    localparam logic [3:0] S_XWAIT  = 4'd9;
    localparam logic [3:0] S_YSTART = 4'd10;
    localparam logic [3:0] S_YWAIT  = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [31:0]        step_length_reg;
    logic [15:0]        turn_angle_reg;
    logic [15:0]        start_heading_reg;
    logic signed [31:0] start_x_reg;
    logic signed [31:0] start_y_reg;

    logic                          cfg_wr;
    logic [tpi_pkg::REG_IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[tpi_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_length_reg   <= tpi_pkg::RST_STEP_LENGTH;
            turn_angle_reg    <= tpi_pkg::RST_TURN_ANGLE;
            start_heading_reg <= tpi_pkg::RST_START_HEADING;
            start_x_reg       <= tpi_pkg::RST_START_X;
            start_y_reg       <= tpi_pkg::RST_START_Y;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                tpi_pkg::REG_STEP_LENGTH:   step_length_reg   <= pwdata;
                tpi_pkg::REG_TURN_ANGLE:    turn_angle_reg    <= pwdata[15:0];
                tpi_pkg::REG_START_HEADING: start_heading_reg <= pwdata[15:0];
                tpi_pkg::REG_START_X:       start_x_reg       <= pwdata;
                tpi_pkg::REG_START_Y:       start_y_reg       <= pwdata;
                default:                    ;   // unmapped: dropped
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            tpi_pkg::REG_STEP_LENGTH:   prdata = step_length_reg;
            tpi_pkg::REG_TURN_ANGLE:    prdata = {16'h0, turn_angle_reg};
            tpi_pkg::REG_START_HEADING: prdata = {16'h0, start_heading_reg};
            tpi_pkg::REG_START_X:       prdata = start_x_reg;
            tpi_pkg::REG_START_Y:       prdata = start_y_reg;
            default:                    prdata = 32'h0;
        endcase
    end

    // ---------------------------------------------------------------------
    // turtle state and sequencer
    // ---------------------------------------------------------------------
    logic [3:0]            state_reg, state_next;
    logic [1:0]            phase_reg, phase_next;
    logic [ANGLE_BITS-1:0] heading_reg, heading_next;
    logic [ANGLE_BITS-1:0] pend_reg, pend_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic signed [31:0]    pos_x_reg, pos_x_next;
    logic signed [31:0]    pos_y_reg, pos_y_next;
    logic [7:0]            sym_reg, sym_next;
    logic                  last_reg, last_next;
    logic                  op_group_reg, op_group_next;  // vertex applies pending turn
    logic                  op_last_reg, op_last_next;    // vertex closes the string
    logic [D_W-1:0]        dist_reg, dist_next;
    logic                  out_valid_reg, out_valid_next;
    logic signed [31:0]    point_x_reg, point_x_next;
    logic signed [31:0]    point_y_reg, point_y_next;
    logic                  last_point_reg, last_point_next;

    // 16-bit register angles brought to ANGLE_BITS
    logic [31:0]           turn32, head32;
    logic [ANGLE_BITS-1:0] turn_a, start_head_a, delta;
    logic                  is_turn;
    logic [D_W-1:0]        travel;

    assign turn32       = {16'h0, turn_angle_reg};
    assign head32       = {16'h0, start_heading_reg};
    assign turn_a       = turn32[ANGLE_BITS-1:0];
    assign start_head_a = head32[ANGLE_BITS-1:0];
    assign delta        = (sym_reg == tpi_pkg::SYM_LEFT) ? turn_a : ('0 - turn_a);
    assign is_turn      = (sym_reg == tpi_pkg::SYM_LEFT) || (sym_reg == tpi_pkg::SYM_RIGHT);
    assign travel       = cnt_reg * step_length_reg;

    // shared units
    logic               cordic_done, scale_done;
    tpi_pkg::cs_t       cs;
    logic signed [31:0] scale_result;
    logic               at_x;

    assign at_x = (state_reg == S_XSTART);

    tpi_cordic #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_CSTART),
        .angle (heading_reg),
        .done  (cordic_done),
        .cs    (cs)
    );

    tpi_scale #(
        .D_W (D_W)
    ) u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  ((state_reg == S_XSTART) || (state_reg == S_YSTART)),
        .d      (dist_reg),
        .coef   (at_x ? cs.cos_v : cs.sin_v),
        .base   (at_x ? pos_x_reg : pos_y_reg),
        .done   (scale_done),
        .result (scale_result)
    );

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        heading_next    = heading_reg;
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        op_group_next   = op_group_reg;
        op_last_next    = op_last_reg;
        dist_next       = dist_reg;
        out_valid_next  = out_valid_reg && !points.ready;
        point_x_next    = point_x_reg;
        point_y_next    = point_y_reg;
        last_point_next = last_point_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (symbols.valid)
                begin
                    sym_next  = symbols.symbol;
                    last_next = symbols.last_symbol;
                    if (phase_reg == PH_START)
                    begin
                        // fresh string: start registers sampled here
                        pos_x_next   = start_x_reg;
                        pos_y_next   = start_y_reg;
                        heading_next = start_head_a;
                        pend_next    = '0;
                        cnt_next     = '0;
                        phase_next   = PH_INIT;
                    end
                    state_next = S_SYM;
                end
            end
            S_SYM:
            begin
                if (sym_reg == tpi_pkg::SYM_FWD)
                begin
                    if (cnt_reg != CNT_MAX)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (phase_reg == PH_TURNS)
                    begin
                        phase_next = PH_FWD;
                    end
                    state_next = S_FLUSH;
                end
                else if (is_turn)
                begin
                    // a turn closes the open run first
                    if (((phase_reg == PH_INIT) && (cnt_reg != '0)) || (phase_reg == PH_FWD))
                    begin
                        op_group_next = (phase_reg == PH_FWD);
                        op_last_next  = 1'b0;
                        state_next    = S_SETUP;
                    end
                    else
                    begin
                        state_next = S_TURN;
                    end
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_TURN:
            begin
                pend_next  = pend_reg + delta;
                cnt_next   = '0;
                phase_next = PH_TURNS;
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (last_reg)
                begin
                    if (phase_reg != PH_INIT)
                    begin
                        op_group_next = 1'b1;
                        op_last_next  = 1'b1;
                        state_next    = S_SETUP;
                    end
                    else if (cnt_reg != '0)
                    begin
                        op_group_next = 1'b0;
                        op_last_next  = 1'b1;
                        state_next    = S_SETUP;
                    end
                    else
                    begin
                        // empty leading run: string ends without a vertex
                        state_next = S_END;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_END:
            begin
                pend_next  = '0;
                cnt_next   = '0;
                phase_next = PH_START;
                state_next = S_IDLE;
            end
            S_SETUP:
            begin
                if (op_group_reg)
                begin
                    heading_next = heading_reg + pend_reg;
                    pend_next    = '0;
                end
                dist_next  = travel;
                cnt_next   = '0;
                state_next = S_CSTART;
            end
            S_CSTART:
            begin
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                if (cordic_done)
                begin
                    state_next = S_XSTART;
                end
            end
            S_XSTART:
            begin
                state_next = S_XWAIT;
            end
            S_XWAIT:
            begin
                if (scale_done)
                begin
                    pos_x_next = scale_result;
                    state_next = S_YSTART;
                end
            end
            S_YSTART:
            begin
                state_next = S_YWAIT;
            end
            S_YWAIT:
            begin
                if (scale_done)
                begin
                    pos_y_next = scale_result;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // output register frees up when the pending beat is taken
                if (!out_valid_reg || points.ready)
                begin
                    out_valid_next  = 1'b1;
                    point_x_next    = pos_x_reg;
                    point_y_next    = pos_y_reg;
                    last_point_next = op_last_reg;
                    state_next      = op_last_reg ? S_END : S_TURN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_START;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            op_group_reg  <= 1'b0;
            op_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pend_reg      <= pend_next;
            cnt_reg       <= cnt_next;
            op_group_reg  <= op_group_next;
            op_last_reg   <= op_last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        heading_reg    <= heading_next;
        pos_x_reg      <= pos_x_next;
        pos_y_reg      <= pos_y_next;
        sym_reg        <= sym_next;
        last_reg       <= last_next;
        dist_reg       <= dist_next;
        point_x_reg    <= point_x_next;
        point_y_reg    <= point_y_next;
        last_point_reg <= last_point_next;
    end

    assign symbols.ready     = (state_reg == S_IDLE);
    assign points.valid      = out_valid_reg;
    assign points.point_x    = point_x_reg;
    assign points.point_y    = point_y_reg;
    assign points.last_point = last_point_reg;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_cordic_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> (state_reg == S_CWAIT))
        else $error("CORDIC finished outside its wait state");

    a_scale_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        scale_done |-> ((state_reg == S_XWAIT) || (state_reg == S_YWAIT)))
        else $error("scale unit finished outside its wait state");

    a_start_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_START) |-> ((pend_reg == '0) && (cnt_reg == '0)))
        else $error("string start with pending turn or count");

    a_beat_to_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (symbols.valid && symbols.ready) |=> (state_reg == S_SYM) && (phase_reg != PH_START))
        else $error("accepted symbol not decoded");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && (!out_valid_reg || points.ready))
        |=> (points.valid && (points.last_point == $past(op_last_reg))))
        else $error("vertex not presented after emit");

endmodule

// ===== dv/turtle_path_interpreter_unit_tb.sv =====
// Self-checking testbench for turtle_path_interpreter_unit: symbol beats in,
// vertex beats out, each vertex checked against a turtle/CORDIC predictor.
// Depends on tpi_pkg and the tpi_sym_if / tpi_pt_if interfaces.
`timescale 1ns / 100ps

module turtle_path_interpreter_unit_tb;

    localparam int          CLK_PERIOD   = 20;
    localparam int          CYCLE_LIMIT  = 3_000_000;
    localparam int          DRAIN_CYCLES = 100;   // room for two vertices, plus margin
    localparam int          HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int          PHASE_SYMS   = 200;   // random symbols per register setting
    localparam int          N_SETTINGS   = 8;
    localparam int          MAX_REPORTS  = 50;
    localparam longint      CORDIC_K_Q30 = 64'sd652032874;
    localparam logic [15:0] COUNT_MAX    = 16'((1 << tpi_pkg::COUNT_BITS_DEF) - 1);
    // index with no register behind it; writes must be ignored
    localparam logic [tpi_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct {
        logic [7:0] symbol;
        logic       last;
        int         gap;
    } sym_beat_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               last;
    } vertex_t;

    // where the turtle is within the current string
    typedef enum logic [1:0] {AT_START, INIT_RUN, IN_TURNS, IN_RUN} walk_phase_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [tpi_pkg::ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tpi_sym_if sym_bus ();
    tpi_pt_if  pt_bus ();

    turtle_path_interpreter_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .symbols (sym_bus),
        .points  (pt_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the register file, as the predictor sees it
    // ------------------------------------------------------------------
    logic [31:0]        cfg_step          = tpi_pkg::RST_STEP_LENGTH;
    logic [15:0]        cfg_turn          = tpi_pkg::RST_TURN_ANGLE;
    logic [15:0]        cfg_start_heading = tpi_pkg::RST_START_HEADING;
    logic signed [31:0] cfg_start_x       = tpi_pkg::RST_START_X;
    logic signed [31:0] cfg_start_y       = tpi_pkg::RST_START_Y;

    // Turtle state of the predictor
    logic signed [31:0] trt_x       = tpi_pkg::RST_START_X;
    logic signed [31:0] trt_y       = tpi_pkg::RST_START_Y;
    logic [15:0]        trt_heading = tpi_pkg::RST_START_HEADING;
    logic [15:0]        trt_pending = '0;
    logic [15:0]        trt_count   = '0;
    walk_phase_t        walk        = AT_START;

    sym_beat_t sym_backlog[$];        // beats waiting for the driver
    vertex_t   expected_vertices[$];  // vertices predicted but not yet seen

    int  syms_queued   = 0;
    int  syms_taken    = 0;
    int  vertices_seen = 0;
    int  fail_count    = 0;
    int  settings_run  = 0;
    int  cycle_count   = 0;

    logic rx_eager  = 1'b0;  // receiver takes every vertex at once
    logic hold_arm  = 1'b0;  // request for the one long hold-off
    logic hold_done = 1'b0;
    int   hold_left = 0;
    wire  hold_active = (hold_left != 0);

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // atan(2^-i) in 32-bit binary angle units
    function automatic longint cordic_atan(input int i);
        case (i)
            0:       return 64'h2000_0000;
            1:       return 64'h12E4_051E;
            2:       return 64'h09FB_385B;
            3:       return 64'h0511_11D4;
            4:       return 64'h028B_0D43;
            5:       return 64'h0145_D7E1;
            6:       return 64'h00A2_F61E;
            7:       return 64'h0051_7C55;
            8:       return 64'h0028_BE53;
            9:       return 64'h0014_5F2F;
            10:      return 64'h000A_2F98;
            11:      return 64'h0005_17CC;
            12:      return 64'h0002_8BE6;
            13:      return 64'h0001_45F3;
            14:      return 64'h0000_A2FA;
            15:      return 64'h0000_517D;
            default: return 64'h0;
        endcase
    endfunction

    // distance (Q16.16) times a Q30 factor, rounded half away from zero
    function automatic longint scaled_leg(input logic [63:0] travel, input longint f);
        logic [63:0]  mag;
        logic [127:0] prod;
        mag  = (f < 0) ? -f : f;
        prod = ({64'd0, travel} * {64'd0, mag} + (128'd1 << 29)) >> 30;
        return (f < 0) ? -$signed(prod[63:0]) : $signed(prod[63:0]);
    endfunction

    function automatic logic signed [31:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // move count*step along the current heading
    task automatic advance_turtle();
        logic [31:0] ang;
        logic [63:0] travel;
        longint      z;
        longint      vx;
        longint      vy;
        longint      nx;
        longint      c_f;
        longint      s_f;
        // fold into [-45, 45) degrees plus a quadrant
        ang = {trt_heading, 16'h0000} + 32'h2000_0000;
        z   = $signed({34'd0, ang[29:0]}) - 64'sd536870912;
        vx  = CORDIC_K_Q30;
        vy  = 0;
        for (int i = 0; i < tpi_pkg::CORDIC_STEPS_DEF; i++)
        begin
            if (z >= 0)
            begin
                nx = vx - (vy >>> i);
                vy = vy + (vx >>> i);
                z  = z - cordic_atan(i);
            end
            else
            begin
                nx = vx + (vy >>> i);
                vy = vy - (vx >>> i);
                z  = z + cordic_atan(i);
            end
            vx = nx;
        end
        case (ang[31:30])
            2'd0:
            begin
                c_f = vx;
                s_f = vy;
            end
            2'd1:
            begin
                c_f = -vy;
                s_f = vx;
            end
            2'd2:
            begin
                c_f = -vx;
                s_f = -vy;
            end
            default:
            begin
                c_f = vy;
                s_f = -vx;
            end
        endcase
        travel = {48'd0, trt_count} * {32'd0, cfg_step};
        trt_x  = clamp_q16(longint'(trt_x) + scaled_leg(travel, c_f));
        trt_y  = clamp_q16(longint'(trt_y) + scaled_leg(travel, s_f));
    endtask

    // turn by the pending amount, then walk the run
    task automatic close_group();
        trt_heading = trt_heading + trt_pending;
        advance_turtle();
        trt_pending = '0;
        trt_count   = '0;
    endtask

    // one accepted symbol beat: update the turtle, queue its vertices
    task automatic predict_vertices(input logic [7:0] sym, input logic is_last);
        logic        turn;
        logic [15:0] delta;
        turn  = (sym == tpi_pkg::SYM_LEFT) || (sym == tpi_pkg::SYM_RIGHT);
        delta = (sym == tpi_pkg::SYM_LEFT) ? cfg_turn : 16'(16'd0 - cfg_turn);
        // start registers are picked up by the first symbol of a string
        if (walk == AT_START)
        begin
            trt_x       = cfg_start_x;
            trt_y       = cfg_start_y;
            trt_heading = cfg_start_heading;
            trt_pending = '0;
            trt_count   = '0;
            walk        = INIT_RUN;
        end
        if (sym == tpi_pkg::SYM_FWD)
        begin
            if (trt_count != COUNT_MAX)
                trt_count = trt_count + 16'd1;
            if (walk == IN_TURNS)
                walk = IN_RUN;
        end
        else if (turn)
        begin
            if (walk == INIT_RUN)
            begin
                // leading run moves without turning
                if (trt_count != 0)
                begin
                    advance_turtle();
                    expected_vertices.push_back('{trt_x, trt_y, 1'b0});
                end
                trt_count = '0;
                walk      = IN_TURNS;
            end
            else if (walk == IN_RUN)
            begin
                close_group();
                expected_vertices.push_back('{trt_x, trt_y, 1'b0});
                walk = IN_TURNS;
            end
            trt_pending = trt_pending + delta;
        end
        // flush; after any turn this always gives the final vertex
        if (is_last)
        begin
            if (walk == INIT_RUN)
            begin
                if (trt_count != 0)
                begin
                    advance_turtle();
                    expected_vertices.push_back('{trt_x, trt_y, 1'b1});
                end
            end
            else
            begin
                close_group();
                expected_vertices.push_back('{trt_x, trt_y, 1'b1});
            end
            trt_pending = '0;
            trt_count   = '0;
            walk        = AT_START;
        end
    endtask

    // one line per mismatch, capped so a broken block cannot flood the log
    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Symbol driver: pops the backlog, waits each beat's gap, then offers it
    // ------------------------------------------------------------------
    sym_beat_t staged;
    logic      staged_valid = 1'b0;
    int        staged_wait  = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sym_bus.valid <= 1'b0;
        end
        else
        begin
            if (sym_bus.valid && sym_bus.ready)
            begin
                predict_vertices(sym_bus.symbol, sym_bus.last_symbol);
                syms_taken++;
            end
            if (!sym_bus.valid || sym_bus.ready)
            begin
                if (!staged_valid && sym_backlog.size() != 0)
                begin
                    staged       = sym_backlog.pop_front();
                    staged_valid = 1'b1;
                    staged_wait  = staged.gap;
                end
                if (staged_valid && staged_wait == 0)
                begin
                    sym_bus.valid       <= 1'b1;
                    sym_bus.symbol      <= staged.symbol;
                    sym_bus.last_symbol <= staged.last;
                    staged_valid = 1'b0;
                end
                else
                begin
                    sym_bus.valid <= 1'b0;
                    if (staged_valid)
                        staged_wait--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long hold-off of the receiver, counted on its own; fires once when armed
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Vertex monitor and receiver: checks each beat, then stalls at random
    // ------------------------------------------------------------------
    int rx_stall_left = 0;

    always @(posedge clk)
    begin
        vertex_t want;
        if (!rst_n)
        begin
            pt_bus.ready <= 1'b0;
        end
        else
        begin
            if (pt_bus.valid && pt_bus.ready)
            begin
                if (expected_vertices.size() == 0)
                begin
                    report_mismatch($sformatf("vertex (%0d, %0d) with nothing expected",
                                              pt_bus.point_x, pt_bus.point_y));
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (pt_bus.point_x !== want.x)
                        report_mismatch($sformatf("vertex %0d point_x %0d, expected %0d",
                                                  vertices_seen, pt_bus.point_x, want.x));
                    if (pt_bus.point_y !== want.y)
                        report_mismatch($sformatf("vertex %0d point_y %0d, expected %0d",
                                                  vertices_seen, pt_bus.point_y, want.y));
                    if (pt_bus.last_point !== want.last)
                        report_mismatch($sformatf("vertex %0d last_point %b, expected %b",
                                                  vertices_seen, pt_bus.last_point, want.last));
                end
                vertices_seen++;
                rx_stall_left = rx_eager ? 0 : $urandom_range(0, 14);
            end
            if (hold_active)
            begin
                pt_bus.ready <= 1'b0;
            end
            else if (rx_stall_left != 0)
            begin
                pt_bus.ready <= 1'b0;
                rx_stall_left--;
            end
            else
            begin
                pt_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d symbols taken, %0d vertices outstanding",
                     cycle_count, syms_taken, expected_vertices.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [tpi_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tpi_pkg::REG_STEP_LENGTH:   cfg_step          = val;
            tpi_pkg::REG_TURN_ANGLE:    cfg_turn          = val[15:0];
            tpi_pkg::REG_START_HEADING: cfg_start_heading = val[15:0];
            tpi_pkg::REG_START_X:       cfg_start_x       = $signed(val);
            tpi_pkg::REG_START_Y:       cfg_start_y       = $signed(val);
            default: ;
        endcase
    endtask

    // read one register back and compare the bits it actually holds
    task automatic check_reg(input logic [tpi_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] want, input logic [31:0] mask);
        logic [31:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== (want & mask))
            report_mismatch($sformatf("register %0d reads %h, expected %h",
                                      idx, got & mask, want & mask));
    endtask

    task automatic check_registers();
        check_reg(tpi_pkg::REG_STEP_LENGTH, cfg_step, 32'hFFFF_FFFF);
        check_reg(tpi_pkg::REG_TURN_ANGLE, {16'd0, cfg_turn}, 32'h0000_FFFF);
        check_reg(tpi_pkg::REG_START_HEADING, {16'd0, cfg_start_heading}, 32'h0000_FFFF);
        check_reg(tpi_pkg::REG_START_X, cfg_start_x, 32'hFFFF_FFFF);
        check_reg(tpi_pkg::REG_START_Y, cfg_start_y, 32'hFFFF_FFFF);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_symbol(input logic [7:0] sym, input logic is_last, input bit burst);
        int gap;
        gap = (burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        sym_backlog.push_back('{sym, is_last, gap});
        syms_queued++;
    endtask

    // block is idle once every beat is taken, every vertex seen and the tail has settled
    task automatic wait_for_drain();
        while (syms_taken != syms_queued || expected_vertices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one string: mostly F/+/-, some noise; broken ones are noise with stray lasts
    task automatic queue_random_string(input bit burst);
        int         len;
        int         roll;
        bit         broken;
        logic [7:0] sym;
        logic       is_last;
        len    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        broken = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++)
        begin
            roll = $urandom_range(0, 99);
            if (broken || roll < 8)
                sym = 8'($urandom_range(0, 255));
            else if (roll < 50)
                sym = tpi_pkg::SYM_FWD;
            else if (roll < 75)
                sym = tpi_pkg::SYM_LEFT;
            else
                sym = tpi_pkg::SYM_RIGHT;
            // broken strings may end early or run on into the next one
            is_last = broken ? ($urandom_range(0, 5) == 0) : (i == len - 1);
            queue_symbol(sym, is_last, burst);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int          sat_start;
        logic [31:0] step_v;
        logic [31:0] turn_v;
        logic [31:0] head_v;
        logic [31:0] sx_v;
        logic [31:0] sy_v;

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        sym_bus.valid       = 1'b0;
        sym_bus.symbol      = '0;
        sym_bus.last_symbol = 1'b0;
        pt_bus.ready        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the register file
        check_registers();
        settings_run++;

        // directed strings at reset settings
        // single step, initial run flushed by the last beat
        queue_symbol(tpi_pkg::SYM_FWD, 1'b1, 1'b0);
        // lone turn: vertex at the start with the heading turned
        queue_symbol(tpi_pkg::SYM_LEFT, 1'b1, 1'b0);
        // turn after a run on the last beat: run vertex, then the empty group
        queue_symbol(tpi_pkg::SYM_FWD, 1'b0, 1'b0);
        queue_symbol(tpi_pkg::SYM_RIGHT, 1'b1, 1'b0);
        // noise alone ends a string with no vertex
        queue_symbol(8'h00, 1'b1, 1'b0);
        // mixed groups with noise in between
        queue_symbol(tpi_pkg::SYM_FWD, 1'b0, 1'b0);
        queue_symbol(tpi_pkg::SYM_RIGHT, 1'b0, 1'b0);
        queue_symbol(tpi_pkg::SYM_RIGHT, 1'b0, 1'b0);
        queue_symbol(tpi_pkg::SYM_FWD, 1'b0, 1'b0);
        queue_symbol(8'hFF, 1'b0, 1'b0);
        queue_symbol(tpi_pkg::SYM_LEFT, 1'b0, 1'b0);
        queue_symbol(tpi_pkg::SYM_FWD, 1'b1, 1'b0);
        // string opening with a turn
        queue_symbol(tpi_pkg::SYM_RIGHT, 1'b0, 1'b0);
        queue_symbol(tpi_pkg::SYM_FWD, 1'b0, 1'b0);
        queue_symbol(tpi_pkg::SYM_FWD, 1'b1, 1'b0);
        // noise as last beat still flushes the initial run
        queue_symbol(tpi_pkg::SYM_FWD, 1'b0, 1'b0);
        queue_symbol(8'h80, 1'b1, 1'b0);
        // turns cancelling out
        queue_symbol(tpi_pkg::SYM_LEFT, 1'b0, 1'b0);
        queue_symbol(tpi_pkg::SYM_RIGHT, 1'b1, 1'b0);
        wait_for_drain();

        // random strings over a range of settings, the extremes first
        for (int k = 0; k < N_SETTINGS; k++)
        begin
            case (k)
                0:
                begin
                    // longest step, no turning, corners of the range: saturates
                    step_v = 32'hFFFF_FFFF;
                    turn_v = 32'd0;
                    head_v = 32'd0;
                    sx_v   = 32'h7FFF_FFFF;
                    sy_v   = 32'h8000_0000;
                end
                1:
                begin
                    step_v = 32'd0;
                    turn_v = 32'hFFFF;
                    head_v = 32'hFFFF;
                    sx_v   = 32'h8000_0000;
                    sy_v   = 32'h7FFF_FFFF;
                end
                2:
                begin
                    // quarter turns land on the quadrant boundaries
                    step_v = 32'h0001_8000;
                    turn_v = 32'h4000;
                    head_v = 32'h2000;
                    sx_v   = 32'd0;
                    sy_v   = 32'd0;
                end
                default:
                begin
                    step_v = ($urandom_range(0, 4) == 0) ? $urandom
                                                         : $urandom_range(0, 32'h0004_0000);
                    turn_v = $urandom_range(0, 32'hFFFF);
                    head_v = $urandom_range(0, 32'hFFFF);
                    sx_v   = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
                    sy_v   = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
                end
            endcase
            write_reg(tpi_pkg::REG_STEP_LENGTH, step_v);
            write_reg(tpi_pkg::REG_TURN_ANGLE, turn_v);
            write_reg(tpi_pkg::REG_START_HEADING, head_v);
            write_reg(tpi_pkg::REG_START_X, sx_v);
            write_reg(tpi_pkg::REG_START_Y, sy_v);
            if (k == 3)
                write_reg(REG_UNMAPPED, $urandom);
            check_registers();
            settings_run++;
            rx_eager <= ($urandom_range(0, 3) == 0);
            // one long receiver hold while the sender keeps pushing
            if (k == 2)
                hold_arm <= 1'b1;

            sat_start = syms_queued;
            while (syms_queued - sat_start < PHASE_SYMS)
            begin
                queue_random_string($urandom_range(0, 3) == 0);
                // now and then the sender goes quiet until the block has emptied
                if ($urandom_range(0, 24) == 0)
                    wait_for_drain();
            end
            wait_for_drain();
        end

        $display("Covered %0d symbol beats and %0d vertex beats over %0d register settings,",
                 syms_taken, vertices_seen, settings_run);
        $display("including a long receiver hold, quadrant edges and coordinate clamping");
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
